@@ rtl/core/fdm_pkg.sv @@
// ----------------------------------------------------------------------------
// fdm_pkg
// Shared constants and types of the feedback delay mixer: default sizes,
// register reset values, gain bundle and output queue sizing.
// ----------------------------------------------------------------------------
package fdm_pkg;

	// default sizes, handed to the top level as parameter defaults
	localparam int unsigned RING_DEPTH_DEF  = 65536;
	localparam int unsigned CHANNELS_DEF    = 2;
	localparam int unsigned SAMPLE_BITS_DEF = 16;

	// register widths and fixed point format of the gains
	localparam int unsigned DELAY_W   = 16;
	localparam int unsigned GAIN_W    = 16;
	localparam int unsigned MIX_W     = 17;
	localparam int unsigned FRAC_BITS = 16;

	localparam logic [DELAY_W-1:0] DELAY_RST = 16'd24000;
	localparam logic [GAIN_W-1:0]  FB_RST    = 16'd32768;
	localparam logic [MIX_W-1:0]   MIX_RST   = 17'd32768;
	localparam logic [MIX_W-1:0]   MIX_UNITY = 17'd65536;

	// configuration port
	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 32;

	// output queue
	localparam int unsigned OFIFO_DEPTH = 8;
	localparam int unsigned OFIFO_AW    = 3;
	localparam int unsigned OFIFO_CW    = 4;

	// gains as seen by the datapath; mix already clamped to unity
	typedef struct packed {
		logic [GAIN_W-1:0] feedback;
		logic [MIX_W-1:0]  mix;
	} gain_t;

endpackage

@@ rtl/core/fdm_cfg.sv @@
// ----------------------------------------------------------------------------
// fdm_cfg
// Register file on the APB port: delay, feedback gain and mix level, with the
// delay reduced modulo the ring depth and the mix clamped to unity.
// ----------------------------------------------------------------------------
module fdm_cfg
	import fdm_pkg::*;
#(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [APB_AW-1:0]                paddr,
	input  logic [APB_DW-1:0]                pwdata,
	output logic [APB_DW-1:0]                prdata,
	output logic                             pready,
	output gain_t                            gains,
	output logic [$clog2(RING_DEPTH)-1:0]    delay_mod
);

	typedef enum logic [1:0] {
		REG_DELAY    = 2'd0,
		REG_FEEDBACK = 2'd1,
		REG_MIX      = 2'd2
	} reg_idx_t;

	localparam int unsigned PTR_W   = $clog2(RING_DEPTH);
	// reciprocal of the depth, exact for every 16-bit dividend
	localparam int unsigned RS      = DELAY_W + PTR_W;
	localparam longint unsigned RECIP = ((64'd1 << RS) + RING_DEPTH - 1) / RING_DEPTH;
	localparam int unsigned RECIP_W = 18;
	localparam int unsigned PROD_W  = DELAY_W + RECIP_W;
	localparam int unsigned RW      = (PTR_W >= DELAY_W) ? PTR_W + 1 : DELAY_W + 1;
	localparam logic [DELAY_W-1:0] QUOT_RST = DELAY_W'(DELAY_RST / RING_DEPTH);
	localparam logic [PTR_W-1:0]   DMOD_RST = PTR_W'(DELAY_RST % RING_DEPTH);

	logic [DELAY_W-1:0] delay_q;
	logic [DELAY_W-1:0] quot_q;
	logic [GAIN_W-1:0]  fb_q;
	logic [MIX_W-1:0]   mix_q;
	logic [MIX_W-1:0]   mixc_q;
	logic [PTR_W-1:0]   dmod_q;

	logic               wr;
	reg_idx_t           idx;
	logic [PROD_W-1:0]  wprod;
	logic [RW-1:0]      rem;
	logic [MIX_W-1:0]   wmix;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wprod  = PROD_W'(pwdata[DELAY_W-1:0]) * PROD_W'(RECIP);
	assign wmix   = pwdata[MIX_W-1:0];

	// remainder from the quotient taken at the write
	always_comb begin
		rem = RW'(delay_q) - RW'(quot_q * RING_DEPTH);
		if (rem >= RW'(RING_DEPTH)) begin
			rem = rem - RW'(RING_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RST;
			quot_q  <= QUOT_RST;
			fb_q    <= FB_RST;
			mix_q   <= MIX_RST;
			mixc_q  <= MIX_RST;
			dmod_q  <= DMOD_RST;
		end else begin
			dmod_q <= rem[PTR_W-1:0];
			if (wr) begin
				case (idx)
					REG_DELAY: begin
						delay_q <= pwdata[DELAY_W-1:0];
						quot_q  <= DELAY_W'(wprod >> RS);
					end
					REG_FEEDBACK: begin
						fb_q <= pwdata[GAIN_W-1:0];
					end
					REG_MIX: begin
						mix_q  <= wmix;
						mixc_q <= (wmix > MIX_UNITY) ? MIX_UNITY : wmix;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			REG_DELAY:    prdata = APB_DW'(delay_q);
			REG_FEEDBACK: prdata = APB_DW'(fb_q);
			REG_MIX:      prdata = APB_DW'(mix_q);
			default:      prdata = '0;
		endcase
	end

	assign gains.feedback = fb_q;
	assign gains.mix      = mixc_q;
	assign delay_mod      = dmod_q;

endmodule

@@ rtl/core/fdm_ring.sv @@
// ----------------------------------------------------------------------------
// fdm_ring
// Delay store of all channels: one write port, one read port, registered
// read data, read returns the old word on a same-address write.
// ----------------------------------------------------------------------------
module fdm_ring
	import fdm_pkg::*;
#(
	parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
	parameter int unsigned CHANNELS    = CHANNELS_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          wr_en,
	input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_ch,
	input  logic [$clog2(RING_DEPTH)-1:0]                 wr_ptr,
	input  logic [SAMPLE_BITS-1:0]                        wr_data,
	input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_ch,
	input  logic [$clog2(RING_DEPTH)-1:0]                 rd_ptr,
	output logic [SAMPLE_BITS-1:0]                        rd_data
);

	localparam int unsigned ENTRIES = CHANNELS * RING_DEPTH;
	localparam int unsigned AW      = $clog2(ENTRIES);

	logic [SAMPLE_BITS-1:0] mem [ENTRIES];
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [AW-1:0]          wa;
	logic [AW-1:0]          ra;

	// each channel owns a contiguous block of RING_DEPTH words
	assign wa = AW'(wr_ch) * AW'(RING_DEPTH) + AW'(wr_ptr);
	assign ra = AW'(rd_ch) * AW'(RING_DEPTH) + AW'(rd_ptr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wa] <= wr_data;
		end
		rd_q <= mem[ra];
	end

	assign rd_data = rd_q;

endmodule

@@ rtl/core/fdm_ofifo.sv @@
// ----------------------------------------------------------------------------
// fdm_ofifo
// Output queue between the pipeline and the master stream side. The caller
// never pushes into a full queue.
// ----------------------------------------------------------------------------
module fdm_ofifo
	import fdm_pkg::*;
#(
	parameter int unsigned W = SAMPLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [W-1:0]        push_data,
	output logic                tvalid,
	input  logic                tready,
	output logic [W-1:0]        tdata,
	output logic [OFIFO_CW-1:0] count
);

	logic [W-1:0]          mem_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0]   wr_q;
	logic [OFIFO_AW-1:0]   rd_q;
	logic [OFIFO_CW-1:0]   cnt_q;
	logic                  pop;

	assign tvalid = (cnt_q != '0);
	assign pop    = tvalid && tready;
	assign tdata  = mem_q[rd_q];
	assign count  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + OFIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + OFIFO_AW'(1);
			end
			cnt_q <= cnt_q + OFIFO_CW'(push) - OFIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/feedback_delay_mix.sv @@
// ----------------------------------------------------------------------------
// feedback_delay_mix
// Feedback echo with dry/wet mix: one ring per channel in a shared store;
// read, mixed, fed back and written back for every sample word.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one word per sample, channel in tdata[0], sample above it.
//   Master stream: one mixed sample word for every accepted input word, in
//   order. APB port: delay (0x0), feedback gain (0x4), mix level (0x8); write
//   them only while no word is outstanding.
// Pipeline and throughput
//   An accepted word passes the read-address, feedback and mix stages and is
//   then written into the output queue, which offers it on the master side.
//   One word per cycle is sustained while results drain: each word costs one
//   read and one write of the delay store, which has one port of each kind.
// Stalling
//   Results queue in an eight-word output buffer. The slave side keeps taking
//   words while a result waits, and drops s_axis_tready once eight words are
//   accepted and not yet delivered; no word is lost or repeated.
// Reset
//   Write pointers return to zero and the store reads as zero. No clearing
//   pass runs: a per-channel fill flag marks which entries hold data, so the
//   block takes words from the first cycle after reset.
// ----------------------------------------------------------------------------
module feedback_delay_mix
	import fdm_pkg::*;
#(
	parameter int unsigned RING_DEPTH  = RING_DEPTH_DEF,
	parameter int unsigned CHANNELS    = CHANNELS_DEF,
	parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// slave stream
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [0] channel_index, [SAMPLE_BITS:1] sample_in, zero pad above
	input  logic [((SAMPLE_BITS + 8) / 8) * 8-1:0] s_axis_tdata,
	// master stream
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [SAMPLE_BITS-1:0] sample_out, zero pad above
	output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
	// configuration
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [APB_AW-1:0]                      paddr,
	input  logic [APB_DW-1:0]                      pwdata,
	output logic [APB_DW-1:0]                      prdata,
	output logic                                   pready
);

	localparam int unsigned SB    = SAMPLE_BITS;
	localparam int unsigned OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int unsigned PTR_W = $clog2(RING_DEPTH);
	localparam int unsigned PW1   = PTR_W + 1;
	localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

	// configuration
	gain_t              gains;
	logic [PTR_W-1:0]   dmod;

	// input side and per-channel pointers
	logic               accept;
	logic [CH_W-1:0]    ch_in;
	logic [SB-1:0]      x_in;
	logic [PTR_W-1:0]   wp_q   [CHANNELS];
	logic               full_q [CHANNELS];
	logic [PTR_W-1:0]   wp_cur;
	logic               full_cur;
	logic               wrap;
	logic [OFIFO_CW-1:0] credit_q;
	logic               pop;

	// stage 1: read address
	logic               v_s1;
	logic [CH_W-1:0]    ch_s1;
	logic [SB-1:0]      x_s1;
	logic [PTR_W-1:0]   wp_s1;
	logic               full_s1;
	logic [PW1-1:0]     rp_wide;
	logic [PTR_W-1:0]   rp;
	logic               known;

	// stage 2: feedback
	logic               v_s2;
	logic [CH_W-1:0]    ch_s2;
	logic [SB-1:0]      x_s2;
	logic [PTR_W-1:0]   wp_s2;
	logic [PTR_W-1:0]   rp_s2;
	logic               known_s2;
	logic [SB-1:0]      rdata;
	logic               hit3;
	logic               hit4;
	logic signed [SB-1:0]  wet;
	logic signed [SB+16:0] fbp;
	logic signed [SB-1:0]  fbt;
	logic signed [SB:0]    fsum;
	logic signed [SB-1:0]  wdata;

	// stage 3: write back and mix
	logic               v_s3;
	logic [CH_W-1:0]    ch_s3;
	logic [PTR_W-1:0]   wp_s3;
	logic [SB-1:0]      wd_s3;
	logic signed [SB-1:0]  wet_s3;
	logic signed [SB-1:0]  x_s3;
	logic signed [SB:0]    diff;
	logic signed [SB+18:0] mprod;
	logic signed [SB+1:0]  ysum;
	logic signed [SB-1:0]  y;

	// stage 4: last write, kept for forwarding
	logic               v_s4;
	logic [CH_W-1:0]    ch_s4;
	logic [PTR_W-1:0]   wp_s4;
	logic [SB-1:0]      wd_s4;

	logic [SB-1:0]      q_data;
	logic [OFIFO_CW-1:0] fifo_cnt;

	fdm_cfg #(
		.RING_DEPTH (RING_DEPTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.gains     (gains),
		.delay_mod (dmod)
	);

	// ---- accept: pick the channel, claim its write slot ----------------------
	// A credit covers every word from acceptance to delivery, so the output
	// queue can never overflow and the pipeline itself never stalls.
	assign s_axis_tready = (credit_q != OFIFO_CW'(OFIFO_DEPTH));
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign ch_in         = (CHANNELS == 1) ? '0 : CH_W'(s_axis_tdata[0]);
	assign x_in          = s_axis_tdata[SB:1];
	assign wp_cur        = wp_q[ch_in];
	assign full_cur      = full_q[ch_in];
	assign wrap          = (wp_cur == PTR_W'(RING_DEPTH - 1));
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				wp_q[c]   <= '0;
				full_q[c] <= 1'b0;
			end
			credit_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
		end else begin
			// advance the write pointer; once it wraps the whole ring holds data
			if (accept) begin
				wp_q[ch_in] <= wrap ? '0 : wp_cur + PTR_W'(1);
				if (wrap) begin
					full_q[ch_in] <= 1'b1;
				end
			end
			credit_q <= credit_q + OFIFO_CW'(accept) - OFIFO_CW'(pop);
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ch_s1   <= ch_in;
		x_s1    <= x_in;
		wp_s1   <= wp_cur;
		full_s1 <= full_cur;
	end

	// ---- stage 1: read position, and whether that entry was ever written ----
	// Writes go in pointer order from zero, so before the first wrap only
	// entries below the write pointer hold data; the rest read as zero.
	always_comb begin
		if (wp_s1 >= dmod) begin
			rp_wide = PW1'(wp_s1) - PW1'(dmod);
		end else begin
			rp_wide = PW1'(wp_s1) + PW1'(RING_DEPTH) - PW1'(dmod);
		end
		rp    = rp_wide[PTR_W-1:0];
		known = full_s1 || (rp < wp_s1);
	end

	fdm_ring #(
		.RING_DEPTH  (RING_DEPTH),
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ring (
		.clk     (clk),
		.wr_en   (v_s3),
		.wr_ch   (ch_s3),
		.wr_ptr  (wp_s3),
		.wr_data (wd_s3),
		.rd_ch   (ch_s1),
		.rd_ptr  (rp),
		.rd_data (rdata)
	);

	always_ff @(posedge clk) begin
		ch_s2    <= ch_s1;
		x_s2     <= x_s1;
		wp_s2    <= wp_s1;
		rp_s2    <= rp;
		known_s2 <= known;
	end

	// ---- stage 2: delayed word and feedback ----------------------------------
	// The read missed the writes of the two words ahead of this one; take the
	// newest of those when it hits the same entry. With a one-sample delay the
	// loop closes through this mux, the gain product and the saturation.
	assign hit3 = v_s3 && (ch_s3 == ch_s2) && (wp_s3 == rp_s2);
	assign hit4 = v_s4 && (ch_s4 == ch_s2) && (wp_s4 == rp_s2);

	always_comb begin
		if (hit3) begin
			wet = wd_s3;
		end else if (hit4) begin
			wet = wd_s4;
		end else if (known_s2) begin
			wet = rdata;
		end else begin
			wet = '0;
		end
		// floor of gain times wet over 2^16: arithmetic shift of the product
		fbp  = $signed({1'b0, gains.feedback}) * wet;
		fbt  = fbp[SB+15:FRAC_BITS];
		fsum = $signed({x_s2[SB-1], x_s2}) + $signed({fbt[SB-1], fbt});
		if (fsum > (SB+1)'(SMAX)) begin
			wdata = SMAX;
		end else if (fsum < (SB+1)'(SMIN)) begin
			wdata = SMIN;
		end else begin
			wdata = fsum[SB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		ch_s3  <= ch_s2;
		wp_s3  <= wp_s2;
		wd_s3  <= wdata;
		wet_s3 <= wet;
		x_s3   <= x_s2;
		ch_s4  <= ch_s3;
		wp_s4  <= wp_s3;
		wd_s4  <= wd_s3;
	end

	// ---- stage 3: dry/wet mix ------------------------------------------------
	// x*(1-m) + wet*m equals x + (wet-x)*m, which needs one multiplier.
	always_comb begin
		diff  = $signed({wet_s3[SB-1], wet_s3}) - $signed({x_s3[SB-1], x_s3});
		mprod = diff * $signed({1'b0, gains.mix});
		ysum  = (SB+2)'(x_s3) + mprod[SB+17:FRAC_BITS];
		if (ysum > (SB+2)'(SMAX)) begin
			y = SMAX;
		end else if (ysum < (SB+2)'(SMIN)) begin
			y = SMIN;
		end else begin
			y = ysum[SB-1:0];
		end
	end

	fdm_ofifo #(
		.W (SB)
	) u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_data (y),
		.tvalid    (m_axis_tvalid),
		.tready    (m_axis_tready),
		.tdata     (q_data),
		.count     (fifo_cnt)
	);

	assign m_axis_tdata = OUT_W'(q_data);

	// ---- checks ----------------------------------------------------------
	a_credit_tally: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q == OFIFO_CW'(v_s1) + OFIFO_CW'(v_s2) + OFIFO_CW'(v_s3) + fifo_cnt)
		else $error("credit count disagrees with words in flight");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (fifo_cnt != OFIFO_CW'(OFIFO_DEPTH)))
		else $error("push into a full output queue");

	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (credit_q != '0))
		else $error("result offered with no outstanding word");

endmodule
